// File: design/sild_pkg.sv
package sild_pkg;

	localparam int unsigned ImagePixels = 20340;
	localparam int unsigned LineDepth   = 1024;
	localparam int unsigned PortCount   = 3;

	localparam int unsigned PosW    = 20;
	localparam int unsigned IdleW   = 17;
	localparam int unsigned ProdW   = 25;
	localparam logic [15:0] TimeoutReset = 16'd1000;
	localparam logic [7:0]  NewlineChar  = 8'h0A;

	typedef enum logic [3:0] {
		KIND_NONE      = 4'd0,
		KIND_CHAR      = 4'd1,
		KIND_LINE_END  = 4'd2,
		KIND_PORT      = 4'd3,
		KIND_IMG_BEGIN = 4'd4,
		KIND_IMG_BYTE  = 4'd5,
		KIND_IMG_LAST  = 4'd6,
		KIND_IMG_CLEAR = 4'd7,
		KIND_OVERFLOW  = 4'd8
	} kind_t;

	typedef struct packed {
		kind_t           kind;
		logic [1:0]      port;
		logic [PosW-1:0] index;
		logic [7:0]      data;
		logic [7:0]      bpp;
		logic [PosW-1:0] count;
	} result_t;

endpackage

// File: design/serial_image_line_demux_top.sv
// Splits a serial byte stream into text line writes and image port transfers. Each
// request is either a received byte or a one millisecond tick and produces exactly one
// result (kind none for ticks and dropped bytes). One request is taken every clock cycle
// while the result side keeps up: the parse state and the image length product are
// updated in a single pass and the result lands in an output register. The idle timeout
// register is written through its own port; the user must write it only while no request
// is in flight, as the block itself does not enforce this.
module serial_image_line_demux_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [7:0]  data_byte,
	input  logic        chunk_start,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  kind,
	output logic [1:0]  port,
	output logic [19:0] index,
	output logic [7:0]  data,
	output logic [7:0]  bits_per_pixel,
	output logic [19:0] byte_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	localparam int unsigned PosW  = sild_pkg::PosW;
	localparam int unsigned IdleW = sild_pkg::IdleW;
	localparam int unsigned ProdW = sild_pkg::ProdW;

	logic [15:0]      timeout_q;
	logic             image_mode_q;
	logic [1:0]       active_port_q;
	logic [7:0]       pixel_depth_q;
	logic [PosW-1:0]  write_pos_q;
	logic [PosW-1:0]  image_bytes_q;
	logic [IdleW-1:0] idle_count_q;
	logic             drop_chunk_q;

	logic             image_mode_n;
	logic [1:0]       active_port_n;
	logic [7:0]       pixel_depth_n;
	logic [PosW-1:0]  write_pos_n;
	logic [PosW-1:0]  image_bytes_n;
	logic [IdleW-1:0] idle_count_n;
	logic             drop_chunk_n;

	logic             cur_mode;
	logic [1:0]       cur_port;
	logic [7:0]       cur_depth;
	logic [PosW-1:0]  cur_pos;
	logic [PosW-1:0]  cur_bytes;
	logic [PosW-1:0]  pos_inc;
	logic             restart;

	logic [ProdW-1:0] bits_prod;
	logic [ProdW-1:0] bits_round;
	logic [ProdW-4:0] len_wide;
	logic [PosW-1:0]  len_sat;

	sild_pkg::result_t res;
	sild_pkg::result_t res_q;
	logic              out_valid_q;
	logic              accept;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = out_valid_q && out_stall;
	assign cfg_ready = 1'b1;

	assign restart   = chunk_start && (idle_count_q > {1'b0, timeout_q});
	assign cur_mode  = restart ? 1'b0 : image_mode_q;
	assign cur_port  = restart ? 2'd0 : active_port_q;
	assign cur_depth = restart ? 8'd0 : pixel_depth_q;
	assign cur_pos   = restart ? '0 : write_pos_q;
	assign cur_bytes = restart ? '0 : image_bytes_q;
	assign pos_inc   = cur_pos + PosW'(1);

	assign bits_prod  = ProdW'(sild_pkg::ImagePixels) * ProdW'(data_byte);
	assign bits_round = bits_prod + ProdW'(7);
	assign len_wide   = bits_round[ProdW-1:3];
	assign len_sat    = (len_wide > (ProdW-3)'({PosW{1'b1}})) ? {PosW{1'b1}}
	                                                          : len_wide[PosW-1:0];

	always_comb begin
		image_mode_n  = image_mode_q;
		active_port_n = active_port_q;
		pixel_depth_n = pixel_depth_q;
		write_pos_n   = write_pos_q;
		image_bytes_n = image_bytes_q;
		idle_count_n  = idle_count_q;
		drop_chunk_n  = drop_chunk_q;
		res           = '{kind: sild_pkg::KIND_NONE, default: '0};
		if (op) begin
			if (idle_count_q != {IdleW{1'b1}}) begin
				idle_count_n = idle_count_q + IdleW'(1);
			end
		end else if (!chunk_start && drop_chunk_q) begin
			res.kind = sild_pkg::KIND_NONE;
		end else begin
			image_mode_n  = cur_mode;
			active_port_n = cur_port;
			pixel_depth_n = cur_depth;
			write_pos_n   = cur_pos;
			image_bytes_n = cur_bytes;
			if (chunk_start) begin
				idle_count_n = '0;
				drop_chunk_n = 1'b0;
			end
			if (cur_mode) begin
				res.port = cur_port;
				if (cur_depth == 8'd0) begin
					if (data_byte == 8'd0) begin
						image_mode_n  = 1'b0;
						active_port_n = 2'd0;
						image_bytes_n = '0;
						write_pos_n   = '0;
						res.kind      = sild_pkg::KIND_IMG_CLEAR;
					end else begin
						pixel_depth_n = data_byte;
						image_bytes_n = len_sat;
						res.kind      = sild_pkg::KIND_IMG_BEGIN;
						res.bpp       = data_byte;
						res.count     = len_sat;
					end
				end else begin
					res.index = cur_pos;
					res.data  = data_byte;
					if (pos_inc >= cur_bytes) begin
						image_mode_n  = 1'b0;
						active_port_n = 2'd0;
						pixel_depth_n = 8'd0;
						write_pos_n   = '0;
						image_bytes_n = '0;
						res.kind      = sild_pkg::KIND_IMG_LAST;
						res.bpp       = cur_depth;
						res.count     = cur_bytes;
					end else begin
						write_pos_n = pos_inc;
						res.kind    = sild_pkg::KIND_IMG_BYTE;
					end
				end
			end else if (data_byte >= 8'd1 && data_byte <= 8'(sild_pkg::PortCount)) begin
				image_mode_n  = 1'b1;
				active_port_n = 2'(data_byte - 8'd1);
				pixel_depth_n = 8'd0;
				write_pos_n   = '0;
				image_bytes_n = '0;
				res.kind      = sild_pkg::KIND_PORT;
				res.port      = 2'(data_byte - 8'd1);
			end else if (cur_pos >= PosW'(sild_pkg::LineDepth - 1)) begin
				image_mode_n  = 1'b0;
				active_port_n = 2'd0;
				pixel_depth_n = 8'd0;
				write_pos_n   = '0;
				image_bytes_n = '0;
				drop_chunk_n  = 1'b1;
				res.kind      = sild_pkg::KIND_OVERFLOW;
			end else begin
				res.index = cur_pos;
				res.data  = data_byte;
				if (data_byte == sild_pkg::NewlineChar) begin
					write_pos_n = '0;
					res.kind    = sild_pkg::KIND_LINE_END;
					res.count   = pos_inc;
				end else begin
					write_pos_n = pos_inc;
					res.kind    = sild_pkg::KIND_CHAR;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q     <= sild_pkg::TimeoutReset;
			image_mode_q  <= 1'b0;
			active_port_q <= 2'd0;
			pixel_depth_q <= 8'd0;
			write_pos_q   <= '0;
			image_bytes_q <= '0;
			idle_count_q  <= '0;
			drop_chunk_q  <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				timeout_q <= cfg_data;
			end
			if (accept) begin
				image_mode_q  <= image_mode_n;
				active_port_q <= active_port_n;
				pixel_depth_q <= pixel_depth_n;
				write_pos_q   <= write_pos_n;
				image_bytes_q <= image_bytes_n;
				idle_count_q  <= idle_count_n;
				drop_chunk_q  <= drop_chunk_n;
				out_valid_q   <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = res_q.kind;
	assign port           = res_q.port;
	assign index          = res_q.index;
	assign data           = res_q.data;
	assign bits_per_pixel = res_q.bpp;
	assign byte_count     = res_q.count;

endmodule
